// ===== src/psa_pkg.sv =====
// ============================================================================
// psa_pkg
// Shared types and constants for the postfix stack ALU.
// ============================================================================
`default_nettype none

package psa_pkg;

    localparam int VALUE_W         = 32;
    localparam int OP_W            = 3;
    localparam int IDX_W           = 10;
    localparam int STATUS_W        = 3;
    localparam int COUNT_OUT_W     = 11;
    localparam int STACK_DEPTH_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK_TOP = 3'd2,
        OP_PEEK_BOT = 3'd3,
        OP_ADD      = 3'd4,
        OP_SUB      = 3'd5,
        OP_MUL      = 3'd6,
        OP_DIV      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_FULL    = 3'd2,
        ST_RANGE   = 3'd3,
        ST_DIVZERO = 3'd4
    } status_t;

    typedef struct packed {
        logic load;
        logic fail;
        logic push;
        logic rd_first;
        logic finish_read;
        logic rd_left;
        logic take_left;
        logic alu;
        logic div_start;
        logic div_zero;
        logic write_back;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic is_push;
        logic is_read;
        logic is_div;
        logic divisor_zero;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/psa_divider.sv =====
// ============================================================================
// psa_divider
// Floor division of signed 32-bit words, restoring, one quotient bit a cycle.
// ============================================================================
`default_nettype none

module psa_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [psa_pkg::VALUE_W-1:0]  dividend,
    input  wire logic [psa_pkg::VALUE_W-1:0]  divisor,
    output logic                              done,
    output logic [psa_pkg::VALUE_W-1:0]       quotient
);

    localparam int W      = psa_pkg::VALUE_W;
    localparam int STEP_W = $clog2(W);

    logic              run_reg;
    logic              fix_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      mr_reg;
    logic              neg_reg;
    logic [W-1:0]      quotient_reg;

    logic [W-1:0]      ml;
    logic [W-1:0]      mr;
    logic [W:0]        shifted;
    logic              ge;
    logic [W:0]        diff;
    logic              rem_nz;

    assign ml      = dividend[W-1] ? (W'(0) - dividend) : dividend;
    assign mr      = divisor[W-1] ? (W'(0) - divisor) : divisor;
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = shifted >= {1'b0, mr_reg};
    assign diff    = shifted - {1'b0, mr_reg};
    assign rem_nz  = rem_reg != W'(0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= fix_reg;
            fix_reg  <= run_reg && (step_reg == STEP_W'(W - 1));
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(W - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= ml;
            mr_reg  <= mr;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
        if (fix_reg)
        begin
            quotient_reg <= neg_reg ? (W'(0) - quo_reg - W'(rem_nz)) : quo_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

`default_nettype wire

// ===== src/psa_datapath.sv =====
// ============================================================================
// psa_datapath
// Stack memory, entry count, operand registers, ALU and divider.
// ============================================================================
`default_nettype none

module psa_datapath #(
    parameter int STACK_DEPTH = psa_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire psa_pkg::cmd_t                   cmd,
    output psa_pkg::dp_status_t                  st,
    input  wire logic [psa_pkg::OP_W-1:0]        req_type,
    input  wire logic [psa_pkg::VALUE_W-1:0]     push_value,
    input  wire logic [psa_pkg::IDX_W-1:0]       peek_index,
    output logic [psa_pkg::VALUE_W-1:0]          result_value,
    output logic [psa_pkg::STATUS_W-1:0]         status,
    output logic [psa_pkg::COUNT_OUT_W-1:0]      entry_count
);

    localparam int W  = psa_pkg::VALUE_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int WW = (CW > psa_pkg::IDX_W) ? CW : psa_pkg::IDX_W;

    logic [W-1:0]      mem [STACK_DEPTH];

    logic [CW-1:0]     count_reg;
    psa_pkg::op_t      op_reg;
    logic [W-1:0]      pv_reg;
    logic [psa_pkg::IDX_W-1:0] idx_reg;
    logic [W-1:0]      rdata_reg;
    logic [W-1:0]      right_reg;
    logic [W-1:0]      left_reg;
    logic [W-1:0]      alu_reg;
    logic [W-1:0]      result_reg;
    psa_pkg::status_t  status_reg;

    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [WW-1:0]     idx_w;
    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     top_w;
    logic [AW-1:0]     first_addr;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [W-1:0]      wr_data;
    logic              wr_en;
    logic [W-1:0]      prod;
    logic [W-1:0]      wb_value;
    logic              div_done;
    logic [W-1:0]      div_quotient;
    psa_pkg::status_t  err_code;

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign idx_w  = WW'(idx_reg);
    assign cnt_w  = WW'(count_reg);
    assign top_w  = cnt_w - WW'(1) - idx_w;

    always_comb
    begin
        err_code = psa_pkg::ST_OK;
        unique case (op_reg) inside
            psa_pkg::OP_PUSH:
            begin
                if (count_reg == CW'(STACK_DEPTH))
                begin
                    err_code = psa_pkg::ST_FULL;
                end
            end
            psa_pkg::OP_POP:
            begin
                if (count_reg == CW'(0))
                begin
                    err_code = psa_pkg::ST_FEW;
                end
            end
            psa_pkg::OP_PEEK_TOP, psa_pkg::OP_PEEK_BOT:
            begin
                if (idx_w >= cnt_w)
                begin
                    err_code = psa_pkg::ST_RANGE;
                end
            end
            psa_pkg::OP_ADD, psa_pkg::OP_SUB, psa_pkg::OP_MUL, psa_pkg::OP_DIV:
            begin
                if (count_reg < CW'(2))
                begin
                    err_code = psa_pkg::ST_FEW;
                end
            end
        endcase
    end

    assign first_addr = (op_reg == psa_pkg::OP_PEEK_TOP) ? top_w[AW-1:0] :
                        (op_reg == psa_pkg::OP_PEEK_BOT) ? idx_w[AW-1:0] :
                        cnt_m1[AW-1:0];
    assign rd_addr    = cmd.rd_left ? cnt_m2[AW-1:0] : first_addr;
    assign wr_en      = cmd.push || cmd.write_back;
    assign wr_addr    = cmd.push ? count_reg[AW-1:0] : cnt_m2[AW-1:0];
    assign wr_data    = cmd.push ? pv_reg : wb_value;
    assign prod       = left_reg * right_reg;
    assign wb_value   = (op_reg == psa_pkg::OP_DIV) ? div_quotient : alu_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_first || cmd.rd_left)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.push)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.finish_read && (op_reg == psa_pkg::OP_POP))
        begin
            count_reg <= cnt_m1;
        end
        else if (cmd.div_zero)
        begin
            count_reg <= cnt_m2;
        end
        else if (cmd.write_back)
        begin
            count_reg <= cnt_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= psa_pkg::op_t'(req_type);
            pv_reg  <= push_value;
            idx_reg <= peek_index;
        end
        if (cmd.rd_left)
        begin
            right_reg <= rdata_reg;
        end
        if (cmd.take_left)
        begin
            left_reg <= rdata_reg;
        end
        if (cmd.alu)
        begin
            case (op_reg)
                psa_pkg::OP_ADD: alu_reg <= left_reg + right_reg;
                psa_pkg::OP_SUB: alu_reg <= left_reg - right_reg;
                default:         alu_reg <= prod;
            endcase
        end
        if (cmd.fail)
        begin
            result_reg <= '0;
            status_reg <= err_code;
        end
        else if (cmd.push)
        begin
            result_reg <= pv_reg;
            status_reg <= psa_pkg::ST_OK;
        end
        else if (cmd.finish_read)
        begin
            result_reg <= rdata_reg;
            status_reg <= psa_pkg::ST_OK;
        end
        else if (cmd.div_zero)
        begin
            result_reg <= '0;
            status_reg <= psa_pkg::ST_DIVZERO;
        end
        else if (cmd.write_back)
        begin
            result_reg <= wb_value;
            status_reg <= psa_pkg::ST_OK;
        end
    end

    psa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (left_reg),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign st.err          = err_code != psa_pkg::ST_OK;
    assign st.is_push      = op_reg == psa_pkg::OP_PUSH;
    assign st.is_read      = (op_reg == psa_pkg::OP_POP) || (op_reg == psa_pkg::OP_PEEK_TOP)
                             || (op_reg == psa_pkg::OP_PEEK_BOT);
    assign st.is_div       = op_reg == psa_pkg::OP_DIV;
    assign st.divisor_zero = right_reg == W'(0);
    assign st.div_done     = div_done;

    assign result_value = result_reg;
    assign status       = status_reg;
    assign entry_count  = psa_pkg::COUNT_OUT_W'(count_reg);

endmodule

`default_nettype wire

// ===== src/psa_controller.sv =====
// ============================================================================
// psa_controller
// Request sequencer: check, memory reads, execute, divide wait, write back.
// ============================================================================
`default_nettype none

module psa_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire psa_pkg::dp_status_t st,
    output psa_pkg::cmd_t            cmd,
    output logic                     busy,
    output logic                     done
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_RD1   = 8'b0000_0100,
        S_RD2   = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.err)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end
                else if (st.is_push)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_RD1;
                end
            end
            S_RD1:
            begin
                if (st.is_read)
                begin
                    cmd.finish_read = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.rd_left = 1'b1;
                    state_next  = S_RD2;
                end
            end
            S_RD2:
            begin
                cmd.take_left = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (!st.is_div)
                begin
                    cmd.alu    = 1'b1;
                    state_next = S_WB;
                end
                else if (st.divisor_zero)
                begin
                    cmd.div_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.write_back = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

endmodule

`default_nettype wire

// ===== src/postfix_stack_alu.sv =====
// ============================================================================
// postfix_stack_alu
// Fixed-depth stack of signed 32-bit words with postfix arithmetic.
// ============================================================================
// Push and error requests end at the check state, pop and peek after one
// read; add/sub/mul read twice, execute and write back. Divide waits on the
// divider, one quotient bit per cycle, unless dividing by zero. Each stack
// read uses the memory's single read port. A new request is taken the cycle
// after done. The receiver cannot stall results. Reset clears the entry
// count and idles the sequencer; stack memory contents are not cleared.
`default_nettype none

module postfix_stack_alu #(
    parameter int STACK_DEPTH = psa_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [psa_pkg::OP_W-1:0]            req_type,
    input  wire logic signed [psa_pkg::VALUE_W-1:0]  push_value,
    input  wire logic [psa_pkg::IDX_W-1:0]           peek_index,
    output logic                                     done,
    output logic signed [psa_pkg::VALUE_W-1:0]       result_value,
    output logic [psa_pkg::STATUS_W-1:0]             status,
    output logic [psa_pkg::COUNT_OUT_W-1:0]          entry_count
);

    psa_pkg::cmd_t                 cmd;
    psa_pkg::dp_status_t           st;
    logic [psa_pkg::VALUE_W-1:0]   value;

    psa_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    psa_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .req_type     (req_type),
        .push_value   (push_value),
        .peek_index   (peek_index),
        .result_value (value),
        .status       (status),
        .entry_count  (entry_count)
    );

    assign result_value = value;

endmodule

`default_nettype wire

// ===== verif/postfix_stack_alu_tb.sv =====
// ============================================================================
// postfix_stack_alu_tb
// Self-checking bench for the postfix stack ALU. A directed table covers the
// empty stack, wrap, divide overflow and divide by zero. Random traffic then
// runs with mixed depths, a fill to the full stack and a drain. A shadow stack
// predicts untyped responses and each one is compared field by field.
// ============================================================================
`timescale 1ns / 1ps

module postfix_stack_alu_tb;

    localparam int DEPTH       = psa_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 50;

    typedef struct packed {
        logic [psa_pkg::VALUE_W-1:0]     value;
        psa_pkg::status_t                st;
        logic [psa_pkg::COUNT_OUT_W-1:0] count;
    } stack_resp_t;

    typedef struct packed {
        psa_pkg::op_t                op;
        logic [psa_pkg::VALUE_W-1:0] value;
        logic [psa_pkg::IDX_W-1:0]   index;
        logic                        typed;
        stack_resp_t                 want;
    } stack_row_t;

    localparam int NUM_DIRECTED = 25;

    // typed rows carry their response; the rest go through the shadow stack
    localparam stack_row_t DIRECTED [NUM_DIRECTED] = '{
        '{psa_pkg::OP_POP,      32'h0,        10'd0,    1'b1,
          '{32'h0,        psa_pkg::ST_FEW,     11'd0}},
        '{psa_pkg::OP_ADD,      32'h0,        10'd0,    1'b1,
          '{32'h0,        psa_pkg::ST_FEW,     11'd0}},
        '{psa_pkg::OP_PEEK_TOP, 32'h0,        10'd0,    1'b1,
          '{32'h0,        psa_pkg::ST_RANGE,   11'd0}},
        '{psa_pkg::OP_PEEK_BOT, 32'h0,        10'd1023, 1'b1,
          '{32'h0,        psa_pkg::ST_RANGE,   11'd0}},
        '{psa_pkg::OP_PUSH,     32'h7FFFFFFF, 10'd0,    1'b1,
          '{32'h7FFFFFFF, psa_pkg::ST_OK,      11'd1}},
        '{psa_pkg::OP_SUB,      32'h0,        10'd0,    1'b1,
          '{32'h0,        psa_pkg::ST_FEW,     11'd1}},
        '{psa_pkg::OP_PUSH,     32'h1,        10'd0,    1'b1,
          '{32'h1,        psa_pkg::ST_OK,      11'd2}},
        '{psa_pkg::OP_ADD,      32'h0,        10'd0,    1'b1,
          '{32'h80000000, psa_pkg::ST_OK,      11'd1}},
        '{psa_pkg::OP_PUSH,     32'hFFFFFFFF, 10'd0,    1'b1,
          '{32'hFFFFFFFF, psa_pkg::ST_OK,      11'd2}},
        '{psa_pkg::OP_DIV,      32'h0,        10'd0,    1'b1,
          '{32'h80000000, psa_pkg::ST_OK,      11'd1}},
        '{psa_pkg::OP_PUSH,     32'h0,        10'd0,    1'b1,
          '{32'h0,        psa_pkg::ST_OK,      11'd2}},
        '{psa_pkg::OP_DIV,      32'h0,        10'd0,    1'b1,
          '{32'h0,        psa_pkg::ST_DIVZERO, 11'd0}},
        '{psa_pkg::OP_PUSH,     32'hFFFFFFF9, 10'd0,    1'b1,
          '{32'hFFFFFFF9, psa_pkg::ST_OK,      11'd1}},
        '{psa_pkg::OP_PUSH,     32'h2,        10'd0,    1'b1,
          '{32'h2,        psa_pkg::ST_OK,      11'd2}},
        '{psa_pkg::OP_DIV,      32'h0,        10'd0,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}},
        '{psa_pkg::OP_PUSH,     32'h80000000, 10'd0,    1'b1,
          '{32'h80000000, psa_pkg::ST_OK,      11'd2}},
        '{psa_pkg::OP_PUSH,     32'h80000000, 10'd0,    1'b1,
          '{32'h80000000, psa_pkg::ST_OK,      11'd3}},
        '{psa_pkg::OP_MUL,      32'h0,        10'd0,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}},
        '{psa_pkg::OP_PEEK_TOP, 32'h0,        10'd0,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}},
        '{psa_pkg::OP_PUSH,     32'h5,        10'd0,    1'b1,
          '{32'h5,        psa_pkg::ST_OK,      11'd3}},
        '{psa_pkg::OP_PEEK_BOT, 32'h0,        10'd0,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}},
        '{psa_pkg::OP_PEEK_TOP, 32'h0,        10'd1,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}},
        '{psa_pkg::OP_PEEK_BOT, 32'h0,        10'd3,    1'b1,
          '{32'h0,        psa_pkg::ST_RANGE,   11'd3}},
        '{psa_pkg::OP_SUB,      32'h0,        10'd0,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}},
        '{psa_pkg::OP_MUL,      32'h0,        10'd0,    1'b0,
          '{32'h0,        psa_pkg::ST_OK,      11'd0}}
    };

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [psa_pkg::OP_W-1:0]           req_type;
    logic signed [psa_pkg::VALUE_W-1:0] push_value;
    logic [psa_pkg::IDX_W-1:0]          peek_index;
    logic                               done;
    logic signed [psa_pkg::VALUE_W-1:0] result_value;
    logic [psa_pkg::STATUS_W-1:0]       status;
    logic [psa_pkg::COUNT_OUT_W-1:0]    entry_count;

    logic [psa_pkg::VALUE_W-1:0] shadow_stack [DEPTH];
    int unsigned                 shadow_depth;
    stack_resp_t                 pending_results [$];
    int                          err_count;
    int                          cycle_cnt;
    bit                          pace_on;

    postfix_stack_alu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .push_value   (push_value),
        .peek_index   (peek_index),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [psa_pkg::VALUE_W-1:0] floor_quot(
        logic signed [psa_pkg::VALUE_W-1:0] lhs,
        logic signed [psa_pkg::VALUE_W-1:0] rhs);
        longint l;
        longint r;
        longint q;
        l = lhs;
        r = rhs;
        q = l / r;
        if ((l % r != 0) && ((l < 0) != (r < 0)))
            q = q - 1;
        return q[psa_pkg::VALUE_W-1:0];
    endfunction

    // shadow stack: one request in, one response out
    function automatic stack_resp_t rpn_apply(stack_row_t rq);
        stack_resp_t                 rsp;
        logic [psa_pkg::VALUE_W-1:0] lhs;
        logic [psa_pkg::VALUE_W-1:0] rhs;
        rsp.value = '0;
        rsp.st    = psa_pkg::ST_OK;
        case (rq.op)
            psa_pkg::OP_PUSH:
                if (shadow_depth >= DEPTH)
                    rsp.st = psa_pkg::ST_FULL;
                else
                begin
                    shadow_stack[shadow_depth] = rq.value;
                    shadow_depth++;
                    rsp.value = rq.value;
                end
            psa_pkg::OP_POP:
                if (shadow_depth == 0)
                    rsp.st = psa_pkg::ST_FEW;
                else
                begin
                    shadow_depth--;
                    rsp.value = shadow_stack[shadow_depth];
                end
            psa_pkg::OP_PEEK_TOP:
                if (rq.index >= shadow_depth)
                    rsp.st = psa_pkg::ST_RANGE;
                else
                    rsp.value = shadow_stack[shadow_depth - 1 - rq.index];
            psa_pkg::OP_PEEK_BOT:
                if (rq.index >= shadow_depth)
                    rsp.st = psa_pkg::ST_RANGE;
                else
                    rsp.value = shadow_stack[rq.index];
            default:
                if (shadow_depth < 2)
                    rsp.st = psa_pkg::ST_FEW;
                else
                begin
                    rhs = shadow_stack[shadow_depth - 1];
                    lhs = shadow_stack[shadow_depth - 2];
                    shadow_depth -= 2;
                    case (rq.op)
                        psa_pkg::OP_ADD:  rsp.value = lhs + rhs;
                        psa_pkg::OP_SUB:  rsp.value = lhs - rhs;
                        psa_pkg::OP_MUL:  rsp.value = lhs * rhs;
                        default:
                            if (rhs == '0)
                                rsp.st = psa_pkg::ST_DIVZERO;
                            else
                                rsp.value = floor_quot(lhs, rhs);
                    endcase
                    if (rsp.st == psa_pkg::ST_OK)
                    begin
                        shadow_stack[shadow_depth] = rsp.value;
                        shadow_depth++;
                    end
                end
        endcase
        rsp.count = shadow_depth[psa_pkg::COUNT_OUT_W-1:0];
        return rsp;
    endfunction

    function automatic stack_row_t random_row(int push_pct);
        stack_row_t rq;
        rq = '0;
        if ($urandom_range(99) < push_pct)
            rq.op = psa_pkg::OP_PUSH;
        else
            rq.op = psa_pkg::op_t'($urandom_range(1, 7));
        case ($urandom_range(9))
            0, 1, 2, 3, 4: rq.value = $urandom;
            5, 6:          rq.value = $urandom_range(20) - 10;
            7:             rq.value = '0;
            8:
                case ($urandom_range(3))
                    0:       rq.value = 32'h7FFFFFFF;
                    1:       rq.value = 32'h80000000;
                    2:       rq.value = 32'hFFFFFFFF;
                    default: rq.value = 32'h1;
                endcase
            default:       rq.value = $signed($urandom) >>> $urandom_range(31);
        endcase
        if (shadow_depth > 0 && $urandom_range(9) < 8)
            rq.index = $urandom_range(shadow_depth - 1);
        else
            rq.index = $urandom_range(1023);
        return rq;
    endfunction

    task automatic pace();
        int pick;
        int gap;
        pick = $urandom_range(99);
        gap  = 0;
        if (pace_on)
        begin
            if (pick >= 95)
                gap = $urandom_range(10, 40);
            else if (pick >= 65)
                gap = $urandom_range(1, 3);
        end
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_req(stack_row_t rq);
        stack_resp_t rsp;
        @(negedge clk);
        start      = 1'b1;
        req_type   = rq.op;
        push_value = rq.value;
        peek_index = rq.index;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rsp = rpn_apply(rq);
        pending_results.push_back(rq.typed ? rq.want : rsp);
    endtask

    task automatic run_random(int n_items, int push_pct);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
                pace_on = ($urandom_range(3) != 0);
            pace();
            send_req(random_row(push_pct));
        end
    endtask

    task automatic idle_until_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        stack_resp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response value=%h status=%0d count=%0d",
                         $time, result_value, status, entry_count);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.value, result_value);
                    err_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    err_count++;
                end
                if (entry_count !== want.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, entry_count);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("postfix_stack_alu test failed");
            $finish;
        end
    end

    initial
    begin
        stack_row_t rq;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = '0;
        push_value   = '0;
        peek_index   = '0;
        shadow_depth = 0;
        err_count    = 0;
        cycle_cnt    = 0;
        pace_on      = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            pace();
            send_req(DIRECTED[i]);
        end

        run_random(400, 45);
        idle_until_drained();

        // fill to the full stack, then work at the limit
        pace_on = 1'b0;
        while (shadow_depth < DEPTH)
        begin
            if ($urandom_range(19) == 0)
                pace_on = ~pace_on;
            pace();
            send_req(random_row(97));
        end
        rq       = '0;
        rq.op    = psa_pkg::OP_PEEK_TOP;
        rq.index = 10'd1023;
        send_req(rq);
        rq.op = psa_pkg::OP_PEEK_BOT;
        send_req(rq);
        rq.op    = psa_pkg::OP_PUSH;
        rq.value = $urandom;
        send_req(rq);
        run_random(16, 50);

        run_random(250, 15);

        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("postfix_stack_alu test passed");
        else
            $display("postfix_stack_alu test failed");
        $finish;
    end

endmodule
